/* hdl/pdpd_pkg.sv */
// Shared types, constants and character classification for the pairwise-deletion distance core.
package pdpd_pkg;

	localparam int COUNT_BITS    = 20;
	localparam int FRACTION_BITS = 16;
	localparam int FRAC_W        = FRACTION_BITS + 1;
	localparam int STEP_BITS     = $clog2(FRACTION_BITS + 1);

	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

	typedef struct packed {
		logic [7:0] base_a;
		logic [7:0] base_b;
		logic       last_site;
	} site_t;

	typedef struct packed {
		logic [COUNT_BITS-1:0] sites_used;
		logic [COUNT_BITS-1:0] mismatch_count;
		logic [FRAC_W-1:0]     distance_fraction;
		logic                  no_sites;
	} result_t;

	typedef enum logic [1:0] {
		ST_ACCUM,
		ST_DIV,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic accept;     // a site transaction completes this cycle
		logic start_div;  // that site is the last one: latch totals, clear counters
		logic div_step;   // run one quotient bit
		logic div_first;  // integer bit: compare without shifting
		logic load_out;   // move the finished result into the output register
	} cmd_t;

	// ASCII codes of the recognized alphabet
	localparam logic [7:0] CH_A   = 8'h41;
	localparam logic [7:0] CH_C   = 8'h43;
	localparam logic [7:0] CH_G   = 8'h47;
	localparam logic [7:0] CH_T   = 8'h54;
	localparam logic [7:0] CH_R   = 8'h52;
	localparam logic [7:0] CH_Y   = 8'h59;
	localparam logic [7:0] CH_S   = 8'h53;
	localparam logic [7:0] CH_W   = 8'h57;
	localparam logic [7:0] CH_K   = 8'h4B;
	localparam logic [7:0] CH_M   = 8'h4D;
	localparam logic [7:0] CH_B   = 8'h42;
	localparam logic [7:0] CH_D   = 8'h44;
	localparam logic [7:0] CH_H   = 8'h48;
	localparam logic [7:0] CH_V   = 8'h56;
	localparam logic [7:0] CH_DOT = 8'h2E;
	localparam logic [7:0] CH_GAP = 8'h2D;
	localparam logic [7:0] CH_N   = 8'h4E;
	localparam logic [7:0] CH_X   = 8'h58;

	function automatic logic is_plain_base(input logic [7:0] c);
		logic r;
		case (c)
			CH_A, CH_C, CH_G, CH_T: r = 1'b1;
			default:                r = 1'b0;
		endcase
		return r;
	endfunction

	function automatic logic is_known(input logic [7:0] c);
		logic r;
		case (c)
			CH_A, CH_C, CH_G, CH_T,
			CH_R, CH_Y, CH_S, CH_W, CH_K, CH_M,
			CH_B, CH_D, CH_H, CH_V,
			CH_DOT, CH_GAP, CH_N, CH_X: r = 1'b1;
			default:                    r = 1'b0;
		endcase
		return r;
	endfunction

endpackage

/* hdl/pdpd_ctrl.sv */
// Controller state machine: site acceptance, divider sequencing and output register valid.
module pdpd_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            site_valid,
	output logic            site_ready,
	input  logic            last_site,
	output logic            result_valid,
	input  logic            result_ready,
	output pdpd_pkg::cmd_t  cmd
);

	pdpd_pkg::state_t state_q, state_d;
	logic [pdpd_pkg::STEP_BITS-1:0] step_q;
	logic out_valid_q;
	logic last_step;
	logic slot_free;

	assign last_step = (step_q == pdpd_pkg::STEP_BITS'(pdpd_pkg::FRACTION_BITS));
	assign slot_free = !out_valid_q || result_ready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			pdpd_pkg::ST_ACCUM: begin
				if (site_valid && last_site) state_d = pdpd_pkg::ST_DIV;
			end
			pdpd_pkg::ST_DIV: begin
				if (last_step) state_d = pdpd_pkg::ST_DONE;
			end
			pdpd_pkg::ST_DONE: begin
				if (slot_free) state_d = pdpd_pkg::ST_ACCUM;
			end
			default: state_d = pdpd_pkg::ST_ACCUM;
		endcase
	end

	always_comb begin
		site_ready    = 1'b0;
		cmd           = '0;
		unique case (state_q)
			pdpd_pkg::ST_ACCUM: begin
				site_ready    = 1'b1;
				cmd.accept    = site_valid;
				cmd.start_div = site_valid && last_site;
			end
			pdpd_pkg::ST_DIV: begin
				cmd.div_step  = 1'b1;
				cmd.div_first = (step_q == '0);
			end
			pdpd_pkg::ST_DONE: begin
				cmd.load_out  = slot_free;
			end
			default: begin
				site_ready    = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= pdpd_pkg::ST_ACCUM;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.start_div) begin
				step_q <= '0;
			end else if (cmd.div_step) begin
				step_q <= step_q + 1'b1;
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign result_valid = out_valid_q;

endmodule

/* hdl/pdpd_dp.sv */
// Datapath: saturating site counters, restoring divider and result register.
module pdpd_dp (
	input  logic              clk,
	input  logic              arst_n,
	input  pdpd_pkg::cmd_t    cmd,
	input  pdpd_pkg::site_t   site,
	output pdpd_pkg::result_t result
);

	localparam int CW = pdpd_pkg::COUNT_BITS;
	localparam int FW = pdpd_pkg::FRAC_W;

	logic [CW-1:0] used_q, mism_q;
	logic [CW-1:0] used_next, mism_next;
	logic [CW-1:0] den_q, num_q, rem_q;
	logic [FW-1:0] quot_q;
	pdpd_pkg::result_t result_q;

	logic both_plain, excluded, differ;
	logic [CW:0] trial;
	logic        take;

	// classify the site and form the updated totals
	always_comb begin
		both_plain = pdpd_pkg::is_plain_base(site.base_a) && pdpd_pkg::is_plain_base(site.base_b);
		excluded   = pdpd_pkg::is_known(site.base_a) && pdpd_pkg::is_known(site.base_b)
		             && !both_plain;
		differ     = both_plain && (site.base_a != site.base_b);
		used_next  = used_q;
		mism_next  = mism_q;
		if (!excluded) begin
			used_next = (used_q == pdpd_pkg::COUNT_MAX) ? used_q : used_q + 1'b1;
			if (differ) begin
				mism_next = (mism_q == pdpd_pkg::COUNT_MAX) ? mism_q : mism_q + 1'b1;
			end
		end
	end

	// one quotient bit per step; the remainder stays below the divisor
	always_comb begin
		trial = cmd.div_first ? {1'b0, rem_q} : {rem_q, 1'b0};
		take  = (trial >= {1'b0, den_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
			mism_q <= '0;
		end else if (cmd.accept) begin
			if (cmd.start_div) begin
				used_q <= '0;
				mism_q <= '0;
			end else begin
				used_q <= used_next;
				mism_q <= mism_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start_div) begin
			den_q  <= used_next;
			num_q  <= mism_next;
			rem_q  <= mism_next;
			quot_q <= '0;
		end else if (cmd.div_step) begin
			quot_q <= {quot_q[FW-2:0], take};
			if (take) begin
				rem_q <= CW'(trial - {1'b0, den_q});
			end else begin
				rem_q <= trial[CW-1:0];
			end
		end
		if (cmd.load_out) begin
			result_q.sites_used        <= den_q;
			result_q.mismatch_count    <= num_q;
			result_q.distance_fraction <= (den_q == '0) ? '0 : quot_q;
			result_q.no_sites          <= (den_q == '0);
		end
	end

	assign result = result_q;

endmodule

/* hdl/dna_pair_distance_pairwise_deletion_core.sv */
// Top level of the pairwise-deletion p-distance core.
// Streams aligned site pairs (one character of each sequence per transaction) and accumulates,
// per sequence pair, the number of used sites and the number of mismatching used sites. A site
// where both characters are plain bases A/C/G/T is used and counts a mismatch when they differ;
// a site where both characters are in the upper-case alphabet A C G T R Y S W K M B D H V . - N X
// but not both plain bases is excluded; any other pair is used as a match. Both counters
// saturate at all ones. Non-final sites are taken one per cycle. The site marked last_site
// closes the pair: the counters clear at once, and a restoring divider forms
// floor(mismatches * 2^16 / sites_used) one quotient bit per cycle, the integer bit first, and
// the result is loaded into the result register once that register is free. From the last site
// until that load no site is taken. The next pair's sites are accepted while a finished
// result still waits in the output register. With no used site, distance_fraction is 0 and
// no_sites is 1.
module dna_pair_distance_pairwise_deletion_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              site_valid,
	output logic              site_ready,
	input  pdpd_pkg::site_t   site,
	output logic              result_valid,
	input  logic              result_ready,
	output pdpd_pkg::result_t result
);

	pdpd_pkg::cmd_t cmd;

	// site acceptance, division steps and the output register handshake
	pdpd_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.site_valid   (site_valid),
		.site_ready   (site_ready),
		.last_site    (site.last_site),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.cmd          (cmd)
	);

	// counters, divider and result payload
	pdpd_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.site   (site),
		.result (result)
	);

endmodule

/* verif/dna_pair_distance_pairwise_deletion_core_test.sv */
// Self-checking testbench for the pairwise-deletion p-distance core.
`timescale 1ns / 1ps

module dna_pair_distance_pairwise_deletion_core_test;

	// Cycles with no transaction on either side before the run is declared hung.
	// The longest legal quiet stretch is the deliberate receiver hold plus one divide.
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int LONG_HOLD      = 400;
	localparam int DRAIN_CYCLES   = 50;
	localparam int QUEUE_DEPTH    = 256;
	localparam int RANDOM_SITES   = 1500;

	logic              clk          = 1'b0;
	logic              arst_n       = 1'b0;
	logic              site_valid   = 1'b0;
	logic              site_ready;
	pdpd_pkg::site_t   site         = '0;
	logic              result_valid;
	logic              result_ready = 1'b0;
	pdpd_pkg::result_t result;

	// Pending site transactions, filled by the stimulus process, drained by the driver.
	pdpd_pkg::site_t   site_q[$];
	// Distances the block owes us, oldest first.
	pdpd_pkg::result_t awaited_distances[$];

	// Running totals of the pair in flight, as the block should hold them.
	longint unsigned used_run     = 0;
	longint unsigned mismatch_run = 0;

	int   error_count  = 0;
	int   idle_cycles  = 0;
	int   send_gap     = 0;
	int   send_odds    = 1;
	int   hold_left    = 0;
	int   take_odds    = 1;
	logic quiet        = 1'b0;	// final stretch: no idling on either side
	logic long_hold_req  = 1'b0;
	logic long_hold_done = 1'b0;

	logic [7:0] plain_set [4]  = '{"A", "C", "G", "T"};
	logic [7:0] vague_set [14] = '{"R", "Y", "S", "W", "K", "M", "B", "D", "H", "V",
		".", "-", "N", "X"};

	dna_pair_distance_pairwise_deletion_core i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.site_valid   (site_valid),
		.site_ready   (site_ready),
		.site         (site),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Character classes
	// ------------------------------------------------------------------
	function automatic logic is_acgt(input logic [7:0] c);
		logic hit;
		hit = 1'b0;
		foreach (plain_set[i])
			if (plain_set[i] == c)
				hit = 1'b1;
		return hit;
	endfunction

	// Upper-case alphabet the distance recognizes: plain bases plus ambiguity, gap, dot, N, X.
	function automatic logic in_alphabet(input logic [7:0] c);
		logic hit;
		hit = is_acgt(c);
		foreach (vague_set[i])
			if (vague_set[i] == c)
				hit = 1'b1;
		return hit;
	endfunction

	function automatic longint unsigned bump(input longint unsigned v);
		return (v >= pdpd_pkg::COUNT_MAX) ? longint'(pdpd_pkg::COUNT_MAX) : v + 1;
	endfunction

	// ------------------------------------------------------------------
	// Predictor: fold one site into the running totals; close the pair on the last site.
	// ------------------------------------------------------------------
	function automatic void tally_site(input pdpd_pkg::site_t s, output logic emit,
		output pdpd_pkg::result_t r);
		logic            both_plain;
		logic            dropped;
		longint unsigned frac;
		both_plain = is_acgt(s.base_a) && is_acgt(s.base_b);
		dropped    = in_alphabet(s.base_a) && in_alphabet(s.base_b) && !both_plain;
		emit       = 1'b0;
		r          = '0;
		if (!dropped) begin
			// A mismatch never outruns the used-site count, even at saturation.
			if (both_plain && s.base_a != s.base_b && mismatch_run < used_run + 1)
				mismatch_run = bump(mismatch_run);
			used_run = bump(used_run);
		end
		if (s.last_site) begin
			frac = (used_run == 0) ? 0 : (mismatch_run << pdpd_pkg::FRACTION_BITS) / used_run;
			r.sites_used        = used_run[pdpd_pkg::COUNT_BITS-1:0];
			r.mismatch_count    = mismatch_run[pdpd_pkg::COUNT_BITS-1:0];
			r.distance_fraction = frac[pdpd_pkg::FRAC_W-1:0];
			r.no_sites          = (used_run == 0);
			emit                = 1'b1;
			used_run            = 0;
			mismatch_run        = 0;
		end
	endfunction

	// Print one line per mismatch and count it.
	task automatic report_mismatch(input string what, input longint unsigned got,
		input longint unsigned want);
		$display("%0t ns: %s: got %0d, expected %0d", $time, what, got, want);
		error_count++;
	endtask

	// ------------------------------------------------------------------
	// Driver: present queued sites, with random gaps between transactions.
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin : drive_sites
		int   gap;
		logic waiting;
		if (!arst_n) begin
			site_valid <= 1'b0;
			site       <= '0;
			send_gap   <= 0;
		end else begin
			// Hold the payload steady until the block takes it.
			waiting = site_valid && !site_ready;
			gap     = send_gap;
			if (!waiting) begin
				if (site_valid) begin
					// Occasionally switch how bursty the sender is; odds 0 means no gaps.
					if ($urandom_range(0, 39) == 0)
						send_odds <= $urandom_range(0, 3);
					if (!quiet && $urandom_range(0, 9) < send_odds)
						gap = $urandom_range(1, 8);
				end
				if (gap > 0) begin
					gap--;
					site_valid <= 1'b0;
				end else if (site_q.size() > 0) begin
					site       <= site_q.pop_front();
					site_valid <= 1'b1;
				end else begin
					site_valid <= 1'b0;
				end
			end
			send_gap <= gap;
		end
	end

	// ------------------------------------------------------------------
	// Receiver: ready with random stall bursts, plus one long hold on request.
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin : drive_ready
		if (!arst_n) begin
			result_ready   <= 1'b0;
			hold_left      <= 0;
			long_hold_done <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left    <= hold_left - 1;
			result_ready <= 1'b0;
		end else if (long_hold_req && !long_hold_done) begin
			// Starve the output long enough for the block to back up into its input.
			hold_left      <= LONG_HOLD;
			long_hold_done <= 1'b1;
			result_ready   <= 1'b0;
		end else if (!quiet && $urandom_range(0, 19) < take_odds * 2) begin
			hold_left    <= $urandom_range(0, 7);
			result_ready <= 1'b0;
		end else begin
			if ($urandom_range(0, 29) == 0)
				take_odds <= $urandom_range(0, 3);
			result_ready <= 1'b1;
		end
	end

	// ------------------------------------------------------------------
	// Monitor: predict on each accepted site, check each accepted result.
	// ------------------------------------------------------------------
	always @(posedge clk) begin : watch_ports
		logic              emit;
		pdpd_pkg::result_t fresh;
		pdpd_pkg::result_t want;
		if (arst_n) begin
			if (site_valid && site_ready) begin
				tally_site(site, emit, fresh);
				if (emit)
					awaited_distances.push_back(fresh);
			end
			if (result_valid && result_ready) begin
				if (awaited_distances.size() == 0) begin
					report_mismatch("result with none awaited, sites_used",
						result.sites_used, 0);
				end else begin
					want = awaited_distances.pop_front();
					if (result.sites_used !== want.sites_used)
						report_mismatch("sites_used", result.sites_used, want.sites_used);
					if (result.mismatch_count !== want.mismatch_count)
						report_mismatch("mismatch_count", result.mismatch_count,
							want.mismatch_count);
					if (result.distance_fraction !== want.distance_fraction)
						report_mismatch("distance_fraction", result.distance_fraction,
							want.distance_fraction);
					if (result.no_sites !== want.no_sites)
						report_mismatch("no_sites", result.no_sites, want.no_sites);
				end
			end
			if ((site_valid && site_ready) || (result_valid && result_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
		end
	end

	// Watchdog: give up when nothing moves for too long.
	always @(posedge clk) begin : watchdog
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("dna_pair_distance_pairwise_deletion_core_test: done, errors");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------
	// Queue one site; hold off while the queue is deep so long pairs stay cheap.
	task automatic push_site(input logic [7:0] a, input logic [7:0] b, input logic last);
		pdpd_pkg::site_t s;
		while (site_q.size() >= QUEUE_DEPTH)
			@(negedge clk);
		s.base_a    = a;
		s.base_b    = b;
		s.last_site = last;
		site_q.push_back(s);
	endtask

	// Draw a character: mostly plain bases, some ambiguity codes, some foreign bytes.
	function automatic logic [7:0] draw_char(input int flavor);
		int pick;
		pick = $urandom_range(0, 99);
		if (flavor == 1)	// a pair that should end up with no used site
			return vague_set[$urandom_range(0, 13)];
		if (pick < 55)
			return plain_set[$urandom_range(0, 3)];
		if (pick < 72)
			return vague_set[$urandom_range(0, 13)];
		if (pick < 85)
			return plain_set[$urandom_range(0, 3)] | 8'h20;	// lower case, unknown
		return 8'($urandom_range(0, 255));
	endfunction

	// Queue one random alignment pair; returns how many sites it sent.
	task automatic push_pair(input int len, output int sent);
		int         flavor;
		logic [7:0] a;
		logic [7:0] b;
		flavor = ($urandom_range(0, 9) == 0) ? 1 : 0;
		for (int i = 0; i < len; i++) begin
			a = draw_char(flavor);
			b = ($urandom_range(0, 1) == 0) ? a : draw_char(flavor);
			push_site(a, b, i == len - 1);
		end
		sent = len;
	endtask

	// Wait until every queued site is taken and every awaited distance has come back.
	task automatic drain;
		while (site_q.size() > 0 || site_valid || awaited_distances.size() > 0)
			@(negedge clk);
	endtask

	initial begin : stimulus
		int sent;
		int total;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: one-site pairs covering match, full mismatch and exclusion.
		push_site("A", "A", 1'b1);
		push_site("A", "C", 1'b1);	// fraction at its top, exactly one
		push_site("N", "A", 1'b1);	// excluded, no used site
		push_site("-", ".", 1'b1);
		push_site("N", "a", 1'b1);	// alphabet char against a foreign one counts as a match
		push_site(8'h00, 8'hFF, 1'b1);	// two foreign bytes: used, match
		push_site(8'hFF, 8'h00, 1'b1);
		// Short multi-site pairs with thirds, quarters and halves.
		push_site("G", "T", 1'b0);
		push_site("T", "T", 1'b0);
		push_site("C", "C", 1'b1);
		push_site("R", "Y", 1'b0);
		push_site("X", "X", 1'b1);	// all sites excluded
		push_site("A", "G", 1'b0);
		push_site("T", "A", 1'b0);
		push_site("C", "G", 1'b0);
		push_site("C", "C", 1'b1);
		push_site("A", "N", 1'b0);
		push_site("G", "g", 1'b0);
		push_site("T", "C", 1'b1);
		push_site("B", "D", 1'b0);
		push_site("H", "V", 1'b0);
		push_site("K", "M", 1'b0);
		push_site("S", "W", 1'b1);

		// Pause the sender until everything is back.
		drain;

		// Random pairs, mostly short, some long.
		total = 0;
		while (total < RANDOM_SITES) begin
			push_pair(($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
				: $urandom_range(1, 8), sent);
			total += sent;
		end

		// Back-pressure: hold the output while short pairs keep arriving.
		long_hold_req = 1'b1;
		for (int i = 0; i < 40; i++)
			push_pair($urandom_range(1, 3), sent);
		drain;

		// Final stretch with no idling, closed by a short mixed pair.
		quiet = 1'b1;
		total = 0;
		while (total < 150) begin
			push_pair($urandom_range(1, 10), sent);
			total += sent;
		end
		push_site("N", "N", 1'b0);
		push_site("A", "T", 1'b0);
		push_site("C", "c", 1'b0);
		push_site("G", "C", 1'b1);

		drain;
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (awaited_distances.size() > 0)
			report_mismatch("distances never delivered", 0, awaited_distances.size());
		if (error_count == 0)
			$display("dna_pair_distance_pairwise_deletion_core_test: done, clean");
		else
			$display("dna_pair_distance_pairwise_deletion_core_test: done, errors");
		$finish;
	end

endmodule
